### hdl/nvis_pkg.sv
// ----------------------------------------------------------------------------
// nvis_pkg
// Shared types and constants of the nearest value index search block:
// command codes, field widths, controller states and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nvis_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int INDEX_BITS  = 11;
   localparam int DIST_BITS   = 32;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load_en;
      logic query_init;
      logic scan_rd;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic pipe_busy;
   } dp_status_type;

endpackage

### hdl/nvis_ctrl.sv
// ----------------------------------------------------------------------------
// nvis_ctrl
// Controller state machine: takes beats on the command channel, sequences
// the scan of the reference store and raises the result strobe.
// ----------------------------------------------------------------------------
module nvis_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_cmd,
   output logic                   busy,
   output logic                   rsp_valid,
   output nvis_pkg::ctrl_cmd_type ctrl_cmd,
   input  nvis_pkg::dp_status_type dp_status
);
   import nvis_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      take;

   assign take = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && (req_cmd == CMD_QUERY)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dp_status.scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!dp_status.pipe_busy) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl_cmd  = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy                = 1'b0;
            ctrl_cmd.load_en    = take && (req_cmd == CMD_LOAD);
            ctrl_cmd.query_init = take && (req_cmd == CMD_QUERY);
         end
         ST_SCAN: begin
            ctrl_cmd.scan_rd = !dp_status.scan_done;
         end
         ST_FLUSH: begin
            busy = 1'b1;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_QUERY)) |=> busy)
      else $error("query beat did not start a scan");

   a_result_after_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_FLUSH) && !$past(dp_status.pipe_busy))
      else $error("result strobe before the scan pipeline drained");

   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("result strobe not followed by idle");

endmodule

### hdl/nvis_datapath.sv
// ----------------------------------------------------------------------------
// nvis_datapath
// Reference store, fill count, overflow flag and the scan pipeline:
// memory read, absolute distance, and running minimum with its position.
// ----------------------------------------------------------------------------
module nvis_datapath #(
   parameter int STORE_DEPTH = 1024,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nvis_pkg::ctrl_cmd_type              ctrl_cmd,
   output nvis_pkg::dp_status_type             dp_status,
   input  logic signed [nvis_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                req_sample_missing,
   input  logic                                req_restart,
   output logic [nvis_pkg::INDEX_BITS-1:0]     rsp_nearest_index,
   output logic [nvis_pkg::DIST_BITS-1:0]      rsp_nearest_distance,
   output logic                                rsp_overflowed
);
   import nvis_pkg::*;

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam int WW = VALUE_BITS + DIST_BITS;

   logic [VALUE_BITS:0]   store_ff [STORE_DEPTH];

   logic [CW-1:0]         count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] sample_value;

   logic [VALUE_BITS-1:0] target_ff;
   logic                  target_miss_ff;
   logic [CW-1:0]         addr_ff, addr_in;

   logic                  v1_ff, v1_in;
   logic [VALUE_BITS:0]   rd_word_ff;
   logic [CW-1:0]         idx1_ff;

   logic                  v2_ff, v2_in;
   logic [VALUE_BITS-1:0] dist_ff, dist_in;
   logic [CW-1:0]         idx2_ff;

   logic                  found_ff, found_in;
   logic [VALUE_BITS-1:0] best_dist_ff, best_dist_in;
   logic [CW-1:0]         best_idx_ff, best_idx_in;

   logic signed [VALUE_BITS:0] diff;
   logic                  take_best;
   logic [WW-1:0]         best_wide;

   assign sample_value = VALUE_BITS'($unsigned(req_sample));

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[AW-1:0];
      if (ctrl_cmd.load_en) begin
         if (req_restart) begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = CW'(1);
         end else if (count_ff < CW'(STORE_DEPTH)) begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= {req_sample_missing, sample_value};
      end
      rd_word_ff <= store_ff[addr_ff[AW-1:0]];
   end

   assign dp_status.scan_done = (addr_ff == count_ff) || target_miss_ff;
   assign dp_status.pipe_busy = v1_ff || v2_ff;

   assign addr_in = ctrl_cmd.query_init ? '0 :
                    ctrl_cmd.scan_rd    ? addr_ff + CW'(1) : addr_ff;
   assign v1_in   = ctrl_cmd.scan_rd;

   assign diff    = $signed({target_ff[VALUE_BITS-1], target_ff})
                  - $signed({rd_word_ff[VALUE_BITS-1], rd_word_ff[VALUE_BITS-1:0]});
   assign dist_in = diff[VALUE_BITS] ? VALUE_BITS'(-diff) : diff[VALUE_BITS-1:0];
   assign v2_in   = v1_ff && !rd_word_ff[VALUE_BITS];

   assign take_best = v2_ff && (!found_ff || (dist_ff < best_dist_ff));

   always_comb begin
      found_in     = found_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (ctrl_cmd.query_init) begin
         found_in     = 1'b0;
         best_dist_in = '0;
         best_idx_in  = '0;
      end else if (take_best) begin
         found_in     = 1'b1;
         best_dist_in = dist_ff;
         best_idx_in  = idx2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         found_ff    <= 1'b0;
         addr_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         found_ff    <= found_in;
         addr_ff     <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.query_init) begin
         target_ff      <= sample_value;
         target_miss_ff <= req_sample_missing;
      end
      idx1_ff      <= addr_ff + CW'(1);
      idx2_ff      <= idx1_ff;
      dist_ff      <= dist_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   assign best_wide            = WW'(best_dist_ff);
   assign rsp_nearest_distance = (best_wide > WW'({DIST_BITS{1'b1}})) ?
                                 {DIST_BITS{1'b1}} : best_wide[DIST_BITS-1:0];
   assign rsp_nearest_index    = INDEX_BITS'(best_idx_ff);
   assign rsp_overflowed       = overflow_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STORE_DEPTH))
      else $error("fill count beyond store depth");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared without reset");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_idx_ff != '0) && (best_idx_ff <= CW'(STORE_DEPTH)))
      else $error("best position outside the store");

endmodule

### hdl/nearest_value_index_search.sv
// ----------------------------------------------------------------------------
// nearest_value_index_search
// One-dimensional nearest value search over a loaded reference list.
//
// A command beat is taken at a rising edge with start high and busy low.
// req_cmd selects a load or a query. A load appends req_sample (with its
// missing mark) to the store, emptying it first when req_restart is set; it
// completes in the same edge, busy stays low and the next beat may follow at
// once. Loads into a full store are dropped and set a sticky overflow flag.
// A query scans the stored entries, one memory read per cycle, and
// returns the 1-based position of the nearest non-missing entry with its
// distance, or zero when there is no answer. Its result strobe follows
// once the scan is done and the single read port of the store and the
// two-stage compare pipe have drained. busy stays high until the result
// strobe ends. rsp_valid marks each result for exactly one cycle; the
// receiver cannot stall it. Reset empties the store and clears the
// overflow flag.
// ----------------------------------------------------------------------------
module nearest_value_index_search #(
   parameter int STORE_DEPTH = 1024,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_cmd,
   input  logic signed [nvis_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                    req_sample_missing,
   input  logic                                    req_restart,
   output logic                                    rsp_valid,
   output logic [nvis_pkg::INDEX_BITS-1:0]         rsp_nearest_index,
   output logic [nvis_pkg::DIST_BITS-1:0]          rsp_nearest_distance,
   output logic                                    rsp_overflowed
);
   import nvis_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   nvis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctrl_cmd  (ctrl_cmd),
      .dp_status (dp_status)
   );

   nvis_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctrl_cmd             (ctrl_cmd),
      .dp_status            (dp_status),
      .req_sample           (req_sample),
      .req_sample_missing   (req_sample_missing),
      .req_restart          (req_restart),
      .rsp_nearest_index    (rsp_nearest_index),
      .rsp_nearest_distance (rsp_nearest_distance),
      .rsp_overflowed       (rsp_overflowed)
   );

endmodule

### tb/nearest_value_index_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_value_index_search_checker
// Watches the command and result channels of the nearest value index search
// block. It keeps its own copy of the reference store, works out the answer
// to every accepted query and compares each result strobe, field by field,
// with the oldest answer still awaited. It reports the number of awaited
// answers and the number of mismatches to the testbench top.
// ----------------------------------------------------------------------------
module nearest_value_index_search_checker #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic                                    req_cmd,
   input  logic signed [nvis_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                    req_sample_missing,
   input  logic                                    req_restart,
   input  logic                                    rsp_valid,
   input  logic [nvis_pkg::INDEX_BITS-1:0]         rsp_nearest_index,
   input  logic [nvis_pkg::DIST_BITS-1:0]          rsp_nearest_distance,
   input  logic                                    rsp_overflowed,
   output int                                      pending_count,
   output int                                      fail_count
);
   import nvis_pkg::*;

   typedef struct packed {
      logic [INDEX_BITS-1:0] index;
      logic [DIST_BITS-1:0]  distance;
      logic                  overflowed;
   } nearest_result_type;

   logic signed [SAMPLE_BITS-1:0] stored_value [STORE_DEPTH];
   logic                          stored_missing [STORE_DEPTH];
   int                            stored_count = 0;
   logic                          overflow_seen = 1'b0;
   nearest_result_type            awaited_results [$];
   int                            awaited_total = 0;
   int                            mismatch_total = 0;

   assign pending_count = awaited_total;
   assign fail_count    = mismatch_total;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_total++;
   endtask

   // Missing entries are skipped, and the strict compare keeps the earliest
   // position on a tie.
   function automatic nearest_result_type search_nearest(
      input logic signed [SAMPLE_BITS-1:0] target,
      input logic                          target_missing
   );
      nearest_result_type best;
      longint             gap;
      bit                 found;
      best = '0;
      found = 1'b0;
      if (!target_missing) begin
         for (int k = 0; k < stored_count; k++) begin
            if (!stored_missing[k]) begin
               gap = longint'(target) - longint'(stored_value[k]);
               if (gap < 0) begin
                  gap = -gap;
               end
               if (!found || gap < longint'(best.distance)) begin
                  found = 1'b1;
                  best.distance = gap[DIST_BITS-1:0];
                  best.index = INDEX_BITS'(k + 1);
               end
            end
         end
      end
      best.overflowed = overflow_seen;
      return best;
   endfunction

   always @(posedge clock) begin
      nearest_result_type want;
      if (reset) begin
         stored_count = 0;
         overflow_seen = 1'b0;
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result beat with no query awaiting it (index %0d)",
                                         rsp_nearest_index));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_nearest_index !== want.index) begin
                  report_mismatch($sformatf("nearest_index got %0d expected %0d",
                                            rsp_nearest_index, want.index));
               end
               if (rsp_nearest_distance !== want.distance) begin
                  report_mismatch($sformatf("nearest_distance got %0d expected %0d",
                                            rsp_nearest_distance, want.distance));
               end
               if (rsp_overflowed !== want.overflowed) begin
                  report_mismatch($sformatf("overflowed got %0b expected %0b",
                                            rsp_overflowed, want.overflowed));
               end
            end
         end
         if (start && !busy) begin
            if (req_cmd == CMD_LOAD) begin
               if (req_restart) begin
                  stored_count = 0;
               end
               if (stored_count < STORE_DEPTH) begin
                  stored_value[stored_count] = req_sample;
                  stored_missing[stored_count] = req_sample_missing;
                  stored_count++;
               end else begin
                  overflow_seen = 1'b1;
               end
            end else begin
               awaited_results.push_back(search_nearest(req_sample, req_sample_missing));
            end
         end
      end
      awaited_total = awaited_results.size();
   end

endmodule

### tb/nearest_value_index_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_value_index_search_tb
// Drives load and query beats into the nearest value index search block and
// gives the verdict. A short directed part covers empty and all-missing
// stores, missing queries, ties and the value extremes; random sequences of
// loads followed by queries around a common center come next, then one long
// run of loads gives a deep scan before more random sequences follow.
// ----------------------------------------------------------------------------
module nearest_value_index_search_tb;
   import nvis_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int QUIET_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 16;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_cmd = CMD_LOAD;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          req_sample_missing = 1'b0;
   logic                          req_restart = 1'b0;
   logic                          rsp_valid;
   logic [INDEX_BITS-1:0]         rsp_nearest_index;
   logic [DIST_BITS-1:0]          rsp_nearest_distance;
   logic                          rsp_overflowed;
   int                            pending_count;
   int                            fail_count;
   int                            quiet_cycles = 0;
   int                            beats_sent = 0;
   bit                            idle_allowed = 1'b1;

   always #5 clock = ~clock;

   nearest_value_index_search #(
      .STORE_DEPTH(DEPTH)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_sample          (req_sample),
      .req_sample_missing  (req_sample_missing),
      .req_restart         (req_restart),
      .rsp_valid           (rsp_valid),
      .rsp_nearest_index   (rsp_nearest_index),
      .rsp_nearest_distance(rsp_nearest_distance),
      .rsp_overflowed      (rsp_overflowed)
   );

   nearest_value_index_search_checker #(
      .STORE_DEPTH(DEPTH)
   ) i_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_sample          (req_sample),
      .req_sample_missing  (req_sample_missing),
      .req_restart         (req_restart),
      .rsp_valid           (rsp_valid),
      .rsp_nearest_index   (rsp_nearest_index),
      .rsp_nearest_distance(rsp_nearest_distance),
      .rsp_overflowed      (rsp_overflowed),
      .pending_count       (pending_count),
      .fail_count          (fail_count)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic pause_sender(input int cycles, input bit until_drained);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
      if (until_drained) begin
         while (pending_count != 0) @(negedge clock);
      end
   endtask

   // The beat is taken at the first rising edge that finds busy low.
   task automatic send_beat(input logic cmd, input logic [SAMPLE_BITS-1:0] value,
                            input logic missing, input logic restart);
      @(negedge clock);
      start <= 1'b1;
      req_cmd <= cmd;
      req_sample <= value;
      req_sample_missing <= missing;
      req_restart <= restart;
      while (busy) @(negedge clock);
      @(posedge clock);
      beats_sent++;
      if (idle_allowed && $urandom_range(0, 99) < 7) begin
         pause_sender($urandom_range(0, 12), 1'b0);
      end
   endtask

   function automatic logic [SAMPLE_BITS-1:0] near_value(input logic [SAMPLE_BITS-1:0] center);
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1, 2: return $urandom;
         default: return center + $urandom_range(0, 64) - 32;
      endcase
   endfunction

   task automatic run_sequence(input bit fresh, input int load_total, input int query_total);
      logic [SAMPLE_BITS-1:0] center;
      center = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200) - 100;
      for (int k = 0; k < load_total; k++) begin
         send_beat(CMD_LOAD, near_value(center), $urandom_range(0, 99) < 15,
                   (fresh && k == 0) || $urandom_range(0, 99) < 3);
      end
      for (int k = 0; k < query_total; k++) begin
         send_beat(CMD_QUERY, near_value(center), $urandom_range(0, 99) < 10,
                   $urandom_range(0, 1) == 1);
      end
   endtask

   initial begin
      int beats_target;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_beat(CMD_QUERY, 5, 1'b0, 1'b0);
      send_beat(CMD_LOAD, 7, 1'b1, 1'b1);
      send_beat(CMD_LOAD, -9, 1'b1, 1'b0);
      send_beat(CMD_QUERY, 0, 1'b0, 1'b0);
      send_beat(CMD_LOAD, 100, 1'b0, 1'b1);
      send_beat(CMD_LOAD, 300, 1'b0, 1'b0);
      send_beat(CMD_LOAD, 200, 1'b0, 1'b0);
      send_beat(CMD_LOAD, -100, 1'b1, 1'b0);
      send_beat(CMD_QUERY, 250, 1'b0, 1'b0);
      send_beat(CMD_QUERY, 150, 1'b0, 1'b1);
      send_beat(CMD_QUERY, 250, 1'b1, 1'b0);
      send_beat(CMD_QUERY, -100, 1'b0, 1'b0);
      send_beat(CMD_LOAD, 32'h8000_0000, 1'b0, 1'b1);
      send_beat(CMD_QUERY, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_beat(CMD_LOAD, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_beat(CMD_QUERY, 0, 1'b0, 1'b0);
      send_beat(CMD_QUERY, 32'h8000_0000, 1'b0, 1'b0);
      send_beat(CMD_LOAD, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_beat(CMD_QUERY, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_beat(CMD_QUERY, 32'hFFFF_FFFF, 1'b0, 1'b1);

      while (beats_sent < 300) begin
         idle_allowed = !(beats_sent >= 150 && beats_sent < 280);
         if ($urandom_range(0, 9) == 0) begin
            run_sequence(1'b0, $urandom_range(0, 4), $urandom_range(1, 3));
         end else if ($urandom_range(0, 19) == 0) begin
            run_sequence(1'b1, $urandom_range(40, 120), $urandom_range(2, 5));
         end else begin
            run_sequence(1'b1, $urandom_range(1, 12), $urandom_range(1, 6));
         end
      end
      idle_allowed = 1'b1;

      pause_sender(0, 1'b1);
      run_sequence(1'b1, 120, 3);

      beats_target = beats_sent + 130;
      while (beats_sent < beats_target) begin
         if ($urandom_range(0, 9) == 0) begin
            run_sequence(1'b0, $urandom_range(0, 4), $urandom_range(1, 3));
         end else begin
            run_sequence(1'b1, $urandom_range(1, 12), $urandom_range(1, 6));
         end
      end

      pause_sender(0, 1'b1);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
